FILE: sv/rmw_pkg.sv
// ---------------------------------------------------------------------------
// rmw_pkg: shared types and constants of the running mean block
// Field widths, word layouts, register indexes and small helper functions.
// ---------------------------------------------------------------------------
package rmw_pkg;

   localparam int CountWidth   = 32;
   localparam int DataWidth    = 32;
   localparam int SumWidth     = 63;
   localparam int ReportWidth  = 32;
   localparam int MagWidth     = DataWidth + 1;
   localparam int ProdWidth    = 2 * MagWidth;
   localparam int StepWidth    = $clog2(MagWidth);
   localparam int CsrIdxWidth  = 1;
   localparam int CsrDataWidth = DataWidth;

   typedef logic [DataWidth-1:0]    data_type;
   typedef logic [SumWidth-1:0]     sum_type;
   typedef logic [CountWidth-1:0]   count_type;
   typedef logic [ReportWidth-1:0]  report_type;
   typedef logic [MagWidth-1:0]     mag_type;
   typedef logic [ProdWidth-1:0]    prod_type;
   typedef logic [StepWidth-1:0]    step_type;
   typedef logic [CsrIdxWidth-1:0]  csr_index_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;

   typedef enum logic {
      KIND_SAMPLE  = 1'b0,
      KIND_RESTART = 1'b1
   } kind_type;

   localparam csr_index_type CSR_SEED_ENABLE = 1'b0;
   localparam csr_index_type CSR_SEED_MEAN   = 1'b1;

   localparam sum_type SumMax = {SumWidth{1'b1}};

   // Count as reported on the result word, saturated at the field maximum.
   function automatic report_type count_report(count_type cnt);
      if (64'(cnt) > 64'({ReportWidth{1'b1}})) begin
         return {ReportWidth{1'b1}};
      end
      return ReportWidth'(cnt);
   endfunction

endpackage

FILE: sv/rmw_if.sv
// ---------------------------------------------------------------------------
// rmw_if: handshake channels of the running mean block
// Sample/restart request channel and result channel, valid/ready.
// ---------------------------------------------------------------------------
interface rmw_req_if;
   import rmw_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   data_type sample;

   modport source (output valid, output kind, output sample, input ready);
   modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface rmw_rsp_if;
   import rmw_pkg::*;

   logic       valid;
   logic       ready;
   data_type   mean;
   sum_type    sum_sq_dev;
   report_type count;

   modport source (output valid, output mean, output sum_sq_dev, output count, input ready);
   modport sink   (input valid, input mean, input sum_sq_dev, input count, output ready);
endinterface

FILE: sv/rmw_div.sv
// ---------------------------------------------------------------------------
// rmw_div: bit-serial restoring divider
// Divides the delta magnitude by the sample count, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rmw_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rmw_pkg::mag_type   dividend,
   input  rmw_pkg::count_type divisor,
   output rmw_pkg::mag_type   quotient,
   output logic              done
);
   import rmw_pkg::*;

   logic      busy_ff, busy_in;
   logic      done_ff, done_in;
   step_type  step_ff, step_in;
   mag_type   qd_ff, qd_in;
   count_type rem_ff, rem_in;
   count_type dvs_ff, dvs_in;

   logic [CountWidth:0] shifted;
   logic [CountWidth:0] diff;
   logic                fits;
   logic                last;

   always_comb begin
      shifted = {rem_ff, qd_ff[MagWidth-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      last    = step_ff == StepWidth'(MagWidth - 1);

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      qd_in   = qd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         qd_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it always fits the count width.
         rem_in  = fits ? diff[CountWidth-1:0] : shifted[CountWidth-1:0];
         qd_in   = {qd_ff[MagWidth-2:0], fits};
         step_in = step_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = qd_ff;
   assign done     = done_ff;

endmodule

FILE: sv/rmw_mul.sv
// ---------------------------------------------------------------------------
// rmw_mul: bit-serial shift-add multiplier
// Multiplies two delta magnitudes, one multiplier bit a cycle.
// ---------------------------------------------------------------------------
module rmw_mul (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  rmw_pkg::mag_type a,
   input  rmw_pkg::mag_type b,
   output rmw_pkg::prod_type product,
   output logic            done
);
   import rmw_pkg::*;

   logic     busy_ff, busy_in;
   logic     done_ff, done_in;
   step_type step_ff, step_in;
   mag_type  mcand_ff, mcand_in;
   mag_type  hi_ff, hi_in;
   mag_type  lo_ff, lo_in;

   logic [MagWidth:0] partial;
   logic              last;

   always_comb begin
      partial = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      last    = step_ff == StepWidth'(MagWidth - 1);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;

      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         mcand_in = a;
         hi_in    = '0;
         lo_in    = b;
      end else if (busy_ff) begin
         // Low half shifts out multiplier bits and takes in product bits.
         hi_in   = partial[MagWidth:1];
         lo_in   = {partial[0], lo_ff[MagWidth-1:1]};
         step_in = step_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign product = {hi_ff, lo_ff};
   assign done    = done_ff;

endmodule

FILE: sv/running_mean_welford.sv
// ---------------------------------------------------------------------------
// running_mean_welford: online mean and sum of squared deviations
// Welford update in fixed point, built from bit-serial divide and multiply.
// ---------------------------------------------------------------------------
// Usage: each word on req_if is either a sample (signed Q16.16) or a restart.
// Every accepted word produces exactly one result word on rsp_if carrying the
// mean (Q16.16), the sum of squared deviations (Q31.32, saturating) and the
// sample count (saturating). A restart clears the aggregate, or, when
// seed_enable is set through the csr_ port, loads count one with seed_mean.
// A sample passes the bit-serial divider (33 steps), the ST_DIFF state, the
// bit-serial multiplier (33 steps) and ST_DONE, which posts its result word.
// A restart goes from ST_IDLE straight to ST_DONE. One sample is worked
// on at a time: the next word is accepted only once ST_DONE has posted the
// result, since the two serial units run one after the other.
// The result sits in an output register: the next word is accepted while a
// stalled result waits; a finished result that finds the register still
// full holds until the receiver takes the old one.
// Reset (synchronous, active high) clears the aggregate, both registers and
// the output valid.
// ---------------------------------------------------------------------------
module running_mean_welford (
   input  logic                   clock,
   input  logic                   reset,
   rmw_req_if.sink                req_if,
   rmw_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  rmw_pkg::csr_index_type csr_index,
   input  rmw_pkg::csr_data_type  csr_wdata
);
   import rmw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIFF,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   count_type  count_ff, count_in;
   data_type   mean_ff, mean_in;
   sum_type    sum_ff, sum_in;
   data_type   sample_ff, sample_in;
   mag_type    mag_ff, mag_in;
   logic       neg_ff, neg_in;
   logic       seed_en_ff, seed_en_in;
   data_type   seed_mean_ff, seed_mean_in;
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_mean_ff, rsp_mean_in;
   sum_type    rsp_sum_ff, rsp_sum_in;
   report_type rsp_count_ff, rsp_count_in;

   logic              accept;
   logic              div_start;
   logic              div_done;
   mag_type           quotient;
   logic              mul_start;
   logic              mul_done;
   prod_type          product;
   logic [DataWidth:0]   delta;
   mag_type              delta_mag;
   logic [DataWidth:0]   delta2;
   mag_type              delta2_mag;
   logic [DataWidth+1:0] mean_next;
   logic [SumWidth+1:0]  sum_total;
   count_type            count_inc;

   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      // Difference of the incoming sample and the current mean, and its size.
      delta     = {req_if.sample[DataWidth-1], req_if.sample} -
                  {mean_ff[DataWidth-1], mean_ff};
      delta_mag = delta[DataWidth] ? (~delta + 1'b1) : delta;
      count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;

      // The quotient is applied with the sign of the difference, which
      // truncates the step toward zero.
      mean_next = neg_ff ?
                  {{2{mean_ff[DataWidth-1]}}, mean_ff} - {1'b0, quotient} :
                  {{2{mean_ff[DataWidth-1]}}, mean_ff} + {1'b0, quotient};

      // Difference of the sample and the updated mean.
      delta2     = {sample_ff[DataWidth-1], sample_ff} -
                   {mean_ff[DataWidth-1], mean_ff};
      delta2_mag = delta2[DataWidth] ? (~delta2 + 1'b1) : delta2;

      // The product never reaches 2^64, so its upper bits are dropped.
      sum_total = {2'b00, sum_ff} + {1'b0, product[SumWidth:0]};
   end

   assign div_start = accept && (req_if.kind == KIND_SAMPLE);
   assign mul_start = state_ff == ST_DIFF;

   rmw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (delta_mag),
      .divisor  (count_inc),
      .quotient (quotient),
      .done     (div_done)
   );

   rmw_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mag_ff),
      .b       (delta2_mag),
      .product (product),
      .done    (mul_done)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      seed_en_in   = seed_en_ff;
      seed_mean_in = seed_mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_count_in = rsp_count_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SEED_ENABLE: seed_en_in   = csr_wdata[0];
            CSR_SEED_MEAN:   seed_mean_in = csr_wdata;
            default:         seed_en_in   = seed_en_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.kind == KIND_RESTART) begin
                  count_in = seed_en_ff ? CountWidth'(1) : '0;
                  mean_in  = seed_en_ff ? seed_mean_ff : '0;
                  sum_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  count_in  = count_inc;
                  sample_in = req_if.sample;
                  mag_in    = delta_mag;
                  neg_in    = delta[DataWidth];
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = mean_next[DataWidth-1:0];
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               sum_in   = (sum_total > {2'b00, SumMax}) ? SumMax : sum_total[SumWidth-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_sum_in   = sum_ff;
               rsp_count_in = count_report(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         sum_ff       <= '0;
         seed_en_ff   <= 1'b0;
         seed_mean_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         sum_ff       <= sum_in;
         seed_en_ff   <= seed_en_in;
         seed_mean_ff <= seed_mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_if.ready      = state_ff == ST_IDLE;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.mean       = rsp_mean_ff;
   assign rsp_if.sum_sq_dev = rsp_sum_ff;
   assign rsp_if.count      = rsp_count_ff;

   // The divider only ever reports completion while the sequencer waits on it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide phase");

   // The multiplier only ever reports completion while the sequencer waits on it.
   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside the multiply phase");

   // A sample always divides by a nonzero count.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> count_ff != '0)
      else $error("division by a zero count");

   // A restart posts its result next and leaves a zero sum.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.kind == KIND_RESTART |=> state_ff == ST_DONE && sum_ff == '0)
      else $error("restart did not clear the sum");

endmodule

FILE: verif/running_mean_welford_checker.sv
// ---------------------------------------------------------------------------
// running_mean_welford_checker: result predictor and comparator
// Watches the request, result and register ports of the running mean block,
// keeps its own fixed point Welford aggregate and compares every result word
// field by field against the oldest predicted aggregate.
// ---------------------------------------------------------------------------
module running_mean_welford_checker (
   input  logic                   clock,
   input  logic                   reset,
   rmw_req_if                     req_mon,
   rmw_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  rmw_pkg::csr_index_type csr_index,
   input  rmw_pkg::csr_data_type  csr_wdata,
   output int                     mismatches,
   output int                     outstanding
);
   import rmw_pkg::*;

   typedef struct packed {
      data_type   mean;
      sum_type    sum_sq_dev;
      report_type count;
   } aggregate_type;

   aggregate_type expected_aggregates[$];

   logic      seed_enable;
   data_type  seed_mean;
   count_type n_samples;
   data_type  mean_acc;
   sum_type   sum_acc;
   int        errors;

   // Applies one word to the aggregate and returns the aggregate as reported.
   function automatic aggregate_type fold_word(kind_type kind, data_type sample);
      aggregate_type res;
      longint        smp, dlt, dlt2, quo;
      logic [63:0]   mag1, mag2, qmag;
      logic [127:0]  prod;
      if (kind == KIND_RESTART) begin
         n_samples = seed_enable ? count_type'(1) : '0;
         mean_acc  = seed_enable ? seed_mean : '0;
         sum_acc   = '0;
      end else begin
         if (n_samples != '1) begin
            n_samples = n_samples + 1'b1;
         end
         smp  = longint'(signed'(sample));
         dlt  = smp - longint'(signed'(mean_acc));
         mag1 = (dlt < 0) ? 64'(-dlt) : 64'(dlt);
         // The quotient truncates toward zero, so divide the magnitude.
         qmag = mag1 / 64'(n_samples);
         quo  = (dlt < 0) ? -longint'(qmag) : longint'(qmag);
         mean_acc = data_type'(longint'(signed'(mean_acc)) + quo);
         dlt2 = smp - longint'(signed'(mean_acc));
         mag2 = (dlt2 < 0) ? 64'(-dlt2) : 64'(dlt2);
         prod = 128'(mag1) * 128'(mag2);
         if (prod > 128'(SumMax - sum_acc)) begin
            sum_acc = SumMax;
         end else begin
            sum_acc = sum_acc + sum_type'(prod);
         end
      end
      res.mean       = mean_acc;
      res.sum_sq_dev = sum_acc;
      res.count      = (64'(n_samples) > 64'({ReportWidth{1'b1}})) ?
                       {ReportWidth{1'b1}} : report_type'(n_samples);
      return res;
   endfunction

   always @(posedge clock) begin
      aggregate_type got, want;
      if (reset) begin
         seed_enable = 1'b0;
         seed_mean   = '0;
         n_samples   = '0;
         mean_acc    = '0;
         sum_acc     = '0;
         errors      = 0;
         expected_aggregates.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEED_ENABLE: seed_enable = csr_wdata[0];
               CSR_SEED_MEAN:   seed_mean   = data_type'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.mean       = rsp_mon.mean;
            got.sum_sq_dev = rsp_mon.sum_sq_dev;
            got.count      = rsp_mon.count;
            if (expected_aggregates.size() == 0) begin
               $error("result word with no word waiting: mean %h sum_sq_dev %h count %h",
                      got.mean, got.sum_sq_dev, got.count);
               errors++;
            end else begin
               want = expected_aggregates.pop_front();
               if (got.mean !== want.mean) begin
                  $error("mean: expected %h, got %h", want.mean, got.mean);
                  errors++;
               end
               if (got.sum_sq_dev !== want.sum_sq_dev) begin
                  $error("sum_sq_dev: expected %h, got %h", want.sum_sq_dev, got.sum_sq_dev);
                  errors++;
               end
               if (got.count !== want.count) begin
                  $error("count: expected %h, got %h", want.count, got.count);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_aggregates.insert(expected_aggregates.size(),
                                       fold_word(req_mon.kind, req_mon.sample));
         end
      end
      mismatches  <= errors;
      outstanding <= expected_aggregates.size();
   end

endmodule

FILE: verif/running_mean_welford_tb.sv
// ---------------------------------------------------------------------------
// running_mean_welford_tb: stimulus and verdict for the running mean block
// Drives sample and restart words with random gaps, stalls the result side
// at random and writes the seed registers between phases. A checker beside
// the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module running_mean_welford_tb;
   import rmw_pkg::*;

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;
   int            mismatches;
   int            outstanding;

   // Set near the end of the run: from then on neither side idles.
   bit calm;
   // A request to the result side to hold off once for a long stretch.
   bit hold_req;

   rmw_req_if req_ch ();
   rmw_rsp_if rsp_ch ();

   running_mean_welford uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   running_mean_welford_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Even with both sides idling at random and the long hold-off, the run
   // ends far below this bound.
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // Offers one word and returns at the edge where it was accepted. The
   // valid stays high, so back-to-back words go out without a gap unless a random gap is drawn.
   task automatic send_word(kind_type kind, data_type sample);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= kind;
      req_ch.sample <= sample;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drops valid and waits until every result word has been taken. The first
   // edge lets the checker count the word accepted at the current edge.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Writes both seed registers, one per edge. Called only while idle.
   task automatic load_seed(logic enable, data_type mean);
      csr_we    <= 1'b1;
      csr_index <= CSR_SEED_ENABLE;
      csr_wdata <= csr_data_type'(enable);
      @(posedge clock);
      csr_index <= CSR_SEED_MEAN;
      csr_wdata <= csr_data_type'(mean);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Sample values: mostly small values around zero so that the sum of
   // squared deviations grows slowly, some full range values, and now and
   // then one of the two extremes, which drives the sum into saturation.
   function automatic data_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1, 2, 3: return data_type'($urandom());
         default: return data_type'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
      endcase
   endfunction

   // Result side: ready comes in random bursts high and low, except that on
   // request it stays low long enough for the output register to fill and
   // the block to stop taking words. Once calm, it stays high.
   initial begin
      int span;
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         if (hold_req && !held) begin
            held         = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            span = $urandom_range(1, 17);
            rsp_ch.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = calm ? 1 : $urandom_range(1, 17);
            rsp_ch.ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin
      logic     seed_en;
      data_type seed_val;
      kind_type kind;

      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.kind   <= KIND_SAMPLE;
      req_ch.sample <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_SEED_ENABLE;
      csr_wdata     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Clearing restart. The first sample sets the mean outright; the
      // extremes that follow make the largest deltas and push the sum into
      // saturation. A restart clears it again and ignores its sample field.
      load_seed(1'b0, '0);
      send_word(KIND_SAMPLE, 32'h0000_0000);
      send_word(KIND_SAMPLE, 32'h7FFF_FFFF);
      send_word(KIND_SAMPLE, 32'h8000_0000);
      send_word(KIND_SAMPLE, 32'h7FFF_FFFF);
      send_word(KIND_SAMPLE, 32'h8000_0000);
      send_word(KIND_SAMPLE, 32'h7FFF_FFFF);
      send_word(KIND_SAMPLE, 32'h0000_0001);
      send_word(KIND_SAMPLE, 32'hFFFF_FFFF);
      send_word(KIND_RESTART, 32'h7FFF_FFFF);
      send_word(KIND_SAMPLE, 32'hFFFF_FFFF);
      send_word(KIND_SAMPLE, 32'h0001_0000);
      wait_drained();

      // Seeded restart at the most negative mean, then samples at the
      // opposite extreme: the second one saturates the sum.
      load_seed(1'b1, 32'h8000_0000);
      send_word(KIND_RESTART, 32'h0000_0000);
      send_word(KIND_SAMPLE, 32'h7FFF_FFFF);
      send_word(KIND_SAMPLE, 32'h8000_0000);
      send_word(KIND_SAMPLE, 32'h7FFF_FFFF);
      wait_drained();

      load_seed(1'b1, 32'h7FFF_FFFF);
      send_word(KIND_RESTART, 32'hFFFF_FFFF);
      send_word(KIND_SAMPLE, 32'h8000_0000);
      send_word(KIND_SAMPLE, 32'h0000_0000);
      wait_drained();

      // With seeding off a restart clears, whatever the seed mean holds.
      load_seed(1'b0, 32'h1234_5678);
      send_word(KIND_RESTART, 32'h8000_0000);
      send_word(KIND_SAMPLE, 32'h0000_0000);
      wait_drained();

      // Random phases, each under its own seed setting and opened by a
      // restart. The sender stops until the block has drained before every
      // register write. The last phase runs without idling on either side.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       begin seed_en = 1'b0; seed_val = '0; end
            1:       begin seed_en = 1'b1; seed_val = 32'h8000_0000; end
            2:       begin seed_en = 1'b1; seed_val = 32'h7FFF_FFFF; end
            3:       begin seed_en = 1'b1; seed_val = data_type'($urandom()); end
            4:       begin seed_en = 1'b0; seed_val = data_type'($urandom()); end
            default: begin seed_en = 1'b1; seed_val = '0; end
         endcase
         load_seed(seed_en, seed_val);
         if (phase == 5) begin
            calm <= 1'b1;
         end
         send_word(KIND_RESTART, data_type'($urandom()));
         for (int i = 0; i < 72; i++) begin
            if (phase == 1 && i == 10) begin
               hold_req <= 1'b1;
            end
            kind = ($urandom_range(0, 15) == 0) ? KIND_RESTART : KIND_SAMPLE;
            send_word(kind, pick_sample());
         end
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
